@@ rtl/core/bsp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package bsp_pkg;

  localparam int MaxRadius  = 63;
  localparam int MaxCanvas  = 4096;
  localparam int SqrtSteps  = 15;
  localparam int DivSteps   = 8;

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_TOOL_MODE  = 3'd0;
  localparam logic [2:0] REG_RADIUS     = 3'd1;
  localparam logic [2:0] REG_BRUSH_COL  = 3'd2;
  localparam logic [2:0] REG_BG_COL     = 3'd3;
  localparam logic [2:0] REG_CANVAS_W   = 3'd4;
  localparam logic [2:0] REG_CANVAS_H   = 3'd5;

  typedef enum logic [2:0] {
    TOOL_PENCIL = 3'd0,
    TOOL_BRUSH  = 3'd1,
    TOOL_MARKER = 3'd2,
    TOOL_SPRAY  = 3'd3,
    TOOL_ERASER = 3'd4
  } tool_t;

  // Per-item context that rides along the whole chain.
  typedef struct packed {
    logic [31:0] cur;
    logic [11:0] px;
    logic [11:0] py;
    logic        inb;
    logic        use_div;
    logic [8:0]  fixed_w;
    logic        sat;
  } bsp_ctx_t;

  // Digit-by-digit square root state.
  typedef struct packed {
    logic [29:0] v;
    logic [17:0] rem;
    logic [14:0] root;
  } bsp_sq_t;

  // Restoring division state.
  typedef struct packed {
    logic [7:0] lo;
    logic [6:0] p;
    logic [7:0] q;
  } bsp_dv_t;

endpackage
`default_nettype wire

@@ rtl/core/bsp_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module bsp_front
  import bsp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [13:0]       center_x,
  input  wire logic [13:0]       center_y,
  input  wire logic [6:0]        cell_col,
  input  wire logic [6:0]        cell_row,
  input  wire logic [31:0]       current_pixel,
  input  wire logic [2:0]        tool_mode,
  input  wire logic [5:0]        radius,
  input  wire logic [12:0]       canvas_width,
  input  wire logic [12:0]       canvas_height,
  output logic                   out_valid,
  output bsp_ctx_t               out_ctx,
  output bsp_sq_t                out_sq
);

  logic [6:0]         edge_len;
  logic signed [7:0]  dx, dy;
  logic signed [14:0] px, py;
  logic [14:0]        dx2, dy2, d2;
  logic [11:0]        r2;
  logic [12:0]        cw, ch;
  logic               in_stamp, in_bounds, disc, band;
  logic [8:0]         col4, edge3;
  bsp_ctx_t           ctx;

  always_comb begin
    edge_len = {radius, 1'b1};
    dx = $signed({1'b0, cell_col}) - $signed({2'b0, radius});
    dy = $signed({1'b0, cell_row}) - $signed({2'b0, radius});
    px = 15'($signed(center_x)) + 15'(dx);
    py = 15'($signed(center_y)) + 15'(dy);
    dx2 = 15'($unsigned(16'(dx) * 16'(dx)));
    dy2 = 15'($unsigned(16'(dy) * 16'(dy)));
    d2  = dx2 + dy2;
    r2  = {6'd0, radius} * {6'd0, radius};
    cw  = (canvas_width  > 13'(MaxCanvas)) ? 13'(MaxCanvas) : canvas_width;
    ch  = (canvas_height > 13'(MaxCanvas)) ? 13'(MaxCanvas) : canvas_height;
    in_stamp  = (cell_col < edge_len) && (cell_row < edge_len);
    in_bounds = !px[14] && !py[14] && (px[13:0] < {1'b0, cw}) && (py[13:0] < {1'b0, ch});
    disc  = d2 <= {3'b0, r2};
    col4  = {cell_col, 2'b00};
    edge3 = 9'(edge_len) + {1'b0, edge_len, 1'b0};
    band  = (col4 >= 9'(edge_len)) && (col4 <= edge3);

    ctx.cur     = current_pixel;
    ctx.px      = px[11:0];
    ctx.py      = py[11:0];
    ctx.inb     = in_bounds;
    ctx.use_div = 1'b0;
    ctx.fixed_w = 9'd0;
    ctx.sat     = 1'b0;
    if (in_stamp) begin
      case (tool_mode)
        TOOL_PENCIL, TOOL_ERASER: ctx.fixed_w = disc ? 9'd256 : 9'd0;
        TOOL_MARKER: ctx.fixed_w = band ? 9'd256 : 9'd0;
        TOOL_BRUSH, TOOL_SPRAY: begin
          if (radius == 6'd0) begin
            ctx.fixed_w = 9'd256;
          end else begin
            ctx.use_div = 1'b1;
          end
        end
        default: ctx.fixed_w = 9'd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_ctx     <= ctx;
      out_sq.v    <= {1'b0, d2[12:0], 16'd0};
      out_sq.rem  <= 18'd0;
      out_sq.root <= 15'd0;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/bsp_sqrt_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
module bsp_sqrt_cell
  import bsp_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     en,
  input  wire logic     in_valid,
  input  wire bsp_ctx_t in_ctx,
  input  wire bsp_sq_t  in_sq,
  output logic          out_valid,
  output bsp_ctx_t      out_ctx,
  output bsp_sq_t       out_sq
);

  logic [17:0] rem_sh, trial;
  bsp_sq_t     nx;

  // One result bit per cell: bring down two operand bits and try to subtract.
  always_comb begin
    rem_sh = {in_sq.rem[15:0], in_sq.v[29:28]};
    trial  = {1'b0, in_sq.root, 2'b01};
    nx.v   = {in_sq.v[27:0], 2'b00};
    if (rem_sh >= trial) begin
      nx.rem  = rem_sh - trial;
      nx.root = {in_sq.root[13:0], 1'b1};
    end else begin
      nx.rem  = rem_sh;
      nx.root = {in_sq.root[13:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_ctx <= in_ctx;
      out_sq  <= nx;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/bsp_div_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
module bsp_div_cell
  import bsp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       en,
  input  wire logic [5:0] radius,
  input  wire logic       in_valid,
  input  wire bsp_ctx_t   in_ctx,
  input  wire bsp_dv_t    in_dv,
  output logic            out_valid,
  output bsp_ctx_t        out_ctx,
  output bsp_dv_t         out_dv
);

  logic [7:0] t;
  bsp_dv_t    nx;

  // One quotient bit per cell; the partial remainder stays below the radius.
  always_comb begin
    t     = {in_dv.p, in_dv.lo[7]};
    nx.lo = {in_dv.lo[6:0], 1'b0};
    if (t >= {2'b00, radius}) begin
      nx.p = 7'(t - {2'b00, radius});
      nx.q = {in_dv.q[6:0], 1'b1};
    end else begin
      nx.p = t[6:0];
      nx.q = {in_dv.q[6:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_ctx <= in_ctx;
      out_dv  <= nx;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/bsp_blend.sv @@
`timescale 1ns / 1ps
`default_nettype none
module bsp_blend
  import bsp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        en,
  input  wire logic [2:0]  tool_mode,
  input  wire logic [31:0] brush_color,
  input  wire logic [31:0] background_color,
  input  wire logic        in_valid,
  input  wire bsp_ctx_t    in_ctx,
  input  wire logic [7:0]  quot,
  output logic             out_valid,
  output logic             write_enable,
  output logic [11:0]      pixel_x,
  output logic [11:0]      pixel_y,
  output logic [31:0]      new_pixel
);

  logic [8:0]  w_raw, w;
  logic [12:0] w13;
  logic [31:0] target, res;
  logic [7:0]  c, tc;
  logic [17:0] acc;
  logic        wr;

  always_comb begin
    if (in_ctx.use_div) begin
      w_raw = in_ctx.sat ? 9'd0 : 9'(9'd256 - {1'b0, quot});
    end else begin
      w_raw = in_ctx.fixed_w;
    end
    // Spray keeps about one twentieth of the weight.
    w13 = {w_raw, 3'b000} + {1'b0, w_raw, 2'b00} + {4'b0, w_raw} + 13'd128;
    w   = (tool_mode == TOOL_SPRAY) ? {1'b0, w13[12:8]} : w_raw;

    target = brush_color;
    case (tool_mode)
      TOOL_ERASER: target = background_color;
      TOOL_MARKER: begin
        for (int k = 0; k < 4; k++) begin
          target[k*8 +: 8] = (in_ctx.cur[k*8 +: 8] < brush_color[k*8 +: 8]) ?
                             in_ctx.cur[k*8 +: 8] : brush_color[k*8 +: 8];
        end
      end
      default: target = brush_color;
    endcase

    for (int k = 0; k < 4; k++) begin
      c  = in_ctx.cur[k*8 +: 8];
      tc = target[k*8 +: 8];
      acc = {10'd0, c} * (18'd256 - {9'd0, w}) + {10'd0, tc} * {9'd0, w} + 18'd128;
      res[k*8 +: 8] = acc[15:8];
    end
    wr = in_ctx.inb && (w != 9'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      write_enable <= wr;
      pixel_x      <= wr ? in_ctx.px : 12'd0;
      pixel_y      <= wr ? in_ctx.py : 12'd0;
      new_pixel    <= wr ? res : 32'd0;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/brush_stamp_pixel_blend.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Brush stamp pixel blend.
// Each transfer on the slave side carries one cell of a square brush stamp:
// the stamp center, the cell column and row, and the canvas pixel now stored
// there. Each transfer on the master side returns one result for that cell:
// tuser is the write enable, tdata the canvas position and blended pixel.
// Tool, radius, colors and canvas size come from the configuration port and
// must only be written while no cell is in flight.
// Each input transfer passes through one front stage (position, bounds,
// distance), fifteen square root cells that each produce one root bit,
// eight division cells that each produce one quotient bit of distance /
// radius, and one blend stage that drives the output register.
// Throughput is one cell per cycle; every cell of the chain hands its item to
// the next in each cycle that the chain advances.
// The chain advances whenever the output register is empty or its result is
// taken. While the receiver stalls with a result waiting, the whole chain,
// bubbles included, holds and s_tready drops until that result is taken.
// Reset clears all valid bits and loads the default register values.
module brush_stamp_pixel_blend
  import bsp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // center_x[13:0], center_y[27:14], cell_col[34:28], cell_row[41:35],
  // current_pixel[73:42], zero padding above
  input  wire logic [79:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // pixel_x[11:0], pixel_y[23:12], new_pixel[55:24]
  output logic [55:0]      m_tdata,
  // write_enable[0]
  output logic             m_tuser,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  logic [2:0]  tool_mode;
  logic [5:0]  radius;
  logic [31:0] brush_color, background_color;
  logic [12:0] canvas_width, canvas_height;
  logic        en;

  always_ff @(posedge clk) begin
    if (rst) begin
      tool_mode        <= 3'd0;
      radius           <= 6'd5;
      brush_color      <= 32'hFF0000FF;
      background_color <= 32'hFFFFFFFF;
      canvas_width     <= 13'd640;
      canvas_height    <= 13'd480;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TOOL_MODE: tool_mode        <= cfg_data[2:0];
        REG_RADIUS:    radius           <= cfg_data[5:0];
        REG_BRUSH_COL: brush_color      <= cfg_data;
        REG_BG_COL:    background_color <= cfg_data;
        REG_CANVAS_W:  canvas_width     <= cfg_data[12:0];
        REG_CANVAS_H:  canvas_height    <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // The output register frees up when empty or when its result is taken.
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  logic      sq_valid [SqrtSteps+1];
  bsp_ctx_t  sq_ctx   [SqrtSteps+1];
  bsp_sq_t   sq_st    [SqrtSteps+1];
  logic      dv_valid [DivSteps+1];
  bsp_ctx_t  dv_ctx   [DivSteps+1];
  bsp_dv_t   dv_st    [DivSteps+1];

  bsp_front u_front (
    .clk           (clk),
    .rst           (rst),
    .en            (en),
    .in_valid      (s_tvalid),
    .center_x      (s_tdata[13:0]),
    .center_y      (s_tdata[27:14]),
    .cell_col      (s_tdata[34:28]),
    .cell_row      (s_tdata[41:35]),
    .current_pixel (s_tdata[73:42]),
    .tool_mode     (tool_mode),
    .radius        (radius),
    .canvas_width  (canvas_width),
    .canvas_height (canvas_height),
    .out_valid     (sq_valid[0]),
    .out_ctx       (sq_ctx[0]),
    .out_sq        (sq_st[0])
  );

  for (genvar i = 0; i < SqrtSteps; i++) begin : g_sqrt
    bsp_sqrt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (sq_valid[i]),
      .in_ctx    (sq_ctx[i]),
      .in_sq     (sq_st[i]),
      .out_valid (sq_valid[i+1]),
      .out_ctx   (sq_ctx[i+1]),
      .out_sq    (sq_st[i+1])
    );
  end

  // The quotient saturates when root >= 256 * radius; otherwise the top
  // seven root bits are already below the radius and seed the remainder.
  logic [14:0] root;
  always_comb begin
    root            = sq_st[SqrtSteps].root;
    dv_valid[0]     = sq_valid[SqrtSteps];
    dv_ctx[0]       = sq_ctx[SqrtSteps];
    dv_ctx[0].sat   = root >= {1'b0, radius, 8'd0};
    dv_st[0].lo     = root[7:0];
    dv_st[0].p      = root[14:8];
    dv_st[0].q      = 8'd0;
  end

  for (genvar j = 0; j < DivSteps; j++) begin : g_div
    bsp_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .radius    (radius),
      .in_valid  (dv_valid[j]),
      .in_ctx    (dv_ctx[j]),
      .in_dv     (dv_st[j]),
      .out_valid (dv_valid[j+1]),
      .out_ctx   (dv_ctx[j+1]),
      .out_dv    (dv_st[j+1])
    );
  end

  bsp_blend u_blend (
    .clk              (clk),
    .rst              (rst),
    .en               (en),
    .tool_mode        (tool_mode),
    .brush_color      (brush_color),
    .background_color (background_color),
    .in_valid         (dv_valid[DivSteps]),
    .in_ctx           (dv_ctx[DivSteps]),
    .quot             (dv_st[DivSteps].q),
    .out_valid        (m_tvalid),
    .write_enable     (m_tuser),
    .pixel_x          (m_tdata[11:0]),
    .pixel_y          (m_tdata[23:12]),
    .new_pixel        (m_tdata[55:24])
  );

endmodule
`default_nettype wire
